@@ rtl/pfwc_pkg.sv @@
package pfwc_pkg;

    localparam int VCO_W      = 32;
    localparam int REF_W      = 26;
    localparam int NINT_W     = 6;
    localparam int FRAC_EXT_W = 24;
    localparam int BYTE_W     = 8;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int CFG_IDX_W  = 1;

    localparam logic [VCO_W-1:0] LOW_BAND_LIMIT = 32'd600000000;
    localparam logic [REF_W-1:0] REF_RESET      = 26'd26000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REF_FREQ  = 1'b0,
        REG_FRAC_MODE = 1'b1
    } cfg_reg_t;

    // One classified request on its way to the divider.
    typedef struct packed {
        logic             band;
        logic [VCO_W-1:0] vco;
    } job_t;

endpackage

@@ rtl/pfwc_ifs.sv @@
interface pfwc_in_if;
    import pfwc_pkg::*;

    logic             valid;
    logic             ready;
    logic [VCO_W-1:0] freq;

    modport source (output valid, output freq, input ready);
    modport sink   (input valid, input freq, output ready);
endinterface

interface pfwc_out_if;
    import pfwc_pkg::*;

    logic              valid;
    logic              ready;
    logic              band_low;
    logic [BYTE_W-1:0] nint_byte;
    logic [BYTE_W-1:0] nfraq_byte0;
    logic [BYTE_W-1:0] nfraq_byte1;
    logic [BYTE_W-1:0] nfraq_byte2;

    modport source (output valid, output band_low, output nint_byte, output nfraq_byte0,
                    output nfraq_byte1, output nfraq_byte2, input ready);
    modport sink   (input valid, input band_low, input nint_byte, input nfraq_byte0,
                    input nfraq_byte1, input nfraq_byte2, output ready);
endinterface

@@ rtl/pfwc_front.sv @@
module pfwc_front (
    input  logic            clk,
    input  logic            rst_n,
    pfwc_in_if.sink         carrier,
    output logic            push_valid,
    output pfwc_pkg::job_t  push_job,
    input  logic            push_ready
);
    import pfwc_pkg::*;

    logic valid_reg;
    logic valid_next;
    job_t job_reg;
    job_t job_next;
    logic take;
    logic push;
    logic band;

    assign push          = valid_reg && push_ready;
    assign carrier.ready = !valid_reg || push_ready;
    assign take          = carrier.valid && carrier.ready;

    // Low band: VCO runs at twice the carrier.
    assign band          = (carrier.freq < LOW_BAND_LIMIT);
    assign job_next.band = band;
    assign job_next.vco  = band ? {carrier.freq[VCO_W-2:0], 1'b0} : carrier.freq;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_reg <= job_next;
        end
    end

    assign push_valid = valid_reg;
    assign push_job   = job_reg;

endmodule

@@ rtl/pfwc_fifo.sv @@
module pfwc_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  pfwc_pkg::job_t  push_job,
    output logic            push_ready,
    output logic            pop_valid,
    output pfwc_pkg::job_t  pop_job,
    input  logic            pop_ready
);
    import pfwc_pkg::*;

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_job    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ rtl/pfwc_div.sv @@
module pfwc_div #(
    parameter int FRAC_BITS = 22
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [pfwc_pkg::REF_W-1:0]  ref_freq,
    input  logic                        frac_mode,
    input  logic                        job_valid,
    input  pfwc_pkg::job_t              job,
    output logic                        job_ready,
    pfwc_out_if.source                  pll_word
);
    import pfwc_pkg::*;

    // One restoring step per stage over vco followed by FRAC_BITS zeros.
    localparam int STEPS = VCO_W + FRAC_BITS;
    localparam int QW    = NINT_W + FRAC_BITS;

    logic             vld_reg  [STEPS];
    logic             vld_next [STEPS];
    logic             band_reg  [STEPS];
    logic             band_next [STEPS];
    logic [REF_W-1:0] rem_reg  [STEPS];
    logic [REF_W-1:0] rem_next [STEPS];
    logic [VCO_W-1:0] dvd_reg  [STEPS];
    logic [VCO_W-1:0] dvd_next [STEPS];
    logic [QW-1:0]    quo_reg  [STEPS];
    logic [QW-1:0]    quo_next [STEPS];

    logic             s_band [STEPS];
    logic [REF_W-1:0] s_rem  [STEPS];
    logic [VCO_W-1:0] s_dvd  [STEPS];
    logic [QW-1:0]    s_quo  [STEPS];
    logic [REF_W:0]   trial  [STEPS];
    logic             ge     [STEPS];

    logic              en;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              band_out_reg;
    logic [BYTE_W-1:0] nint_out_reg;
    logic [BYTE_W-1:0] nint_out_next;
    logic [BYTE_W-1:0] b0_out_reg;
    logic [BYTE_W-1:0] b0_out_next;
    logic [BYTE_W-1:0] b1_out_reg;
    logic [BYTE_W-1:0] b1_out_next;
    logic [BYTE_W-1:0] b2_out_reg;
    logic [BYTE_W-1:0] b2_out_next;
    logic [NINT_W-1:0]     nint;
    logic [FRAC_EXT_W-1:0] frac_ext;
    logic                  ref_zero;

    // Whole pipe moves together; it stops only while a result waits unclaimed.
    assign en        = !out_valid_reg || pll_word.ready;
    assign job_ready = en;

    always_comb
    begin
        for (int i = 0; i < STEPS; i++)
        begin
            if (i == 0)
            begin
                vld_next[i] = job_valid;
                s_band[i]   = job.band;
                s_rem[i]    = '0;
                s_dvd[i]    = job.vco;
                s_quo[i]    = '0;
            end
            else
            begin
                vld_next[i] = vld_reg[i-1];
                s_band[i]   = band_reg[i-1];
                s_rem[i]    = rem_reg[i-1];
                s_dvd[i]    = dvd_reg[i-1];
                s_quo[i]    = quo_reg[i-1];
            end
            trial[i]     = {s_rem[i], s_dvd[i][VCO_W-1]};
            ge[i]        = (trial[i] >= {1'b0, ref_freq});
            rem_next[i]  = ge[i] ? REF_W'(trial[i] - {1'b0, ref_freq}) : trial[i][REF_W-1:0];
            dvd_next[i]  = {s_dvd[i][VCO_W-2:0], 1'b0};
            quo_next[i]  = {s_quo[i][QW-2:0], ge[i]};
            band_next[i] = s_band[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STEPS; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int i = 0; i < STEPS; i++)
            begin
                vld_reg[i] <= vld_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < STEPS; i++)
            begin
                band_reg[i] <= band_next[i];
                rem_reg[i]  <= rem_next[i];
                dvd_reg[i]  <= dvd_next[i];
                quo_reg[i]  <= quo_next[i];
            end
        end
    end

    // Byte packing; a zero reference yields zero N and fraction.
    assign ref_zero = (ref_freq == '0);
    assign nint     = ref_zero ? '0 : quo_reg[STEPS-1][QW-1:FRAC_BITS];
    assign frac_ext = ref_zero ? '0 : FRAC_EXT_W'(quo_reg[STEPS-1][FRAC_BITS-1:0]);

    assign nint_out_next = {nint, frac_mode, 1'b0};
    assign b0_out_next   = frac_ext[7:0];
    assign b1_out_next   = frac_ext[15:8];
    assign b2_out_next   = {1'b0, frac_ext[21:16], 1'b1};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (en)
        begin
            out_valid_next = vld_reg[STEPS-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && vld_reg[STEPS-1])
        begin
            band_out_reg <= band_reg[STEPS-1];
            nint_out_reg <= nint_out_next;
            b0_out_reg   <= b0_out_next;
            b1_out_reg   <= b1_out_next;
            b2_out_reg   <= b2_out_next;
        end
    end

    assign pll_word.valid       = out_valid_reg;
    assign pll_word.band_low    = band_out_reg;
    assign pll_word.nint_byte   = nint_out_reg;
    assign pll_word.nfraq_byte0 = b0_out_reg;
    assign pll_word.nfraq_byte1 = b1_out_reg;
    assign pll_word.nfraq_byte2 = b2_out_reg;

endmodule

@@ rtl/pll_frequency_word_calc_top.sv @@
// Fractional-N PLL divider word calculator.
// carrier  (sink): one beat per requested carrier frequency in Hz (freq).
// pll_word (source): one beat per request, in order: band_low plus the
//   integer byte and three fraction bytes for the PLL registers.
// cfg_we/cfg_index/cfg_data: register writes, REG_REF_FREQ (reference in Hz)
//   and REG_FRAC_MODE (fractional-N flag). Write only while no beat is in flight.
// Front stage classifies the band and forms the VCO frequency; a 2-entry queue
//   decouples it from the back end, a long divider pipelined one quotient bit
//   per stage over 32 + FRAC_BITS stages, then an output register.
// Throughput: one beat per cycle while pll_word.ready is held high, set by the one-bit-per-stage divider pipe.
// Path: a carrier beat passes the front register, the queue, the divider
//   stages and the output register to pll_word, plus any receiver stall.
// Stall: when pll_word.ready is low with a result held, the divider pipe
//   freezes; the queue and front register keep taking beats until full, then
//   carrier.ready drops. No beat is lost or repeated.
// Reset: pipe and queue empty, ref_freq = 26 MHz, fractional mode off.
module pll_frequency_word_calc_top #(
    parameter int FRAC_BITS = 22
) (
    input  logic                           clk,
    input  logic                           rst_n,
    pfwc_in_if.sink                        carrier,
    pfwc_out_if.source                     pll_word,
    input  logic                           cfg_we,
    input  pfwc_pkg::cfg_reg_t             cfg_index,
    input  logic [pfwc_pkg::REF_W-1:0]     cfg_data
);
    import pfwc_pkg::*;

    logic [REF_W-1:0] ref_freq_reg;
    logic [REF_W-1:0] ref_freq_next;
    logic             frac_mode_reg;
    logic             frac_mode_next;

    logic push_valid;
    job_t push_job;
    logic push_ready;
    logic pop_valid;
    job_t pop_job;
    logic pop_ready;

    // Config registers: the user must keep values put while beats are in flight; the block does not enforce this.
    always_comb
    begin
        ref_freq_next  = ref_freq_reg;
        frac_mode_next = frac_mode_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_REF_FREQ:  ref_freq_next  = cfg_data;
                REG_FRAC_MODE: frac_mode_next = cfg_data[0];
                default:       ref_freq_next  = ref_freq_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_freq_reg  <= REF_RESET;
            frac_mode_reg <= 1'b0;
        end
        else
        begin
            ref_freq_reg  <= ref_freq_next;
            frac_mode_reg <= frac_mode_next;
        end
    end

    // Front: accept and classify.
    pfwc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .carrier    (carrier),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready)
    );

    // Short queue so front and back stall independently.
    pfwc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_job    (pop_job),
        .pop_ready  (pop_ready)
    );

    // Back: pipelined long division and byte packing.
    pfwc_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ref_freq  (ref_freq_reg),
        .frac_mode (frac_mode_reg),
        .job_valid (pop_valid),
        .job       (pop_job),
        .job_ready (pop_ready),
        .pll_word  (pll_word)
    );

    // Forced marker bits of the register bytes.
    a_byte_marks: assert property (@(posedge clk) disable iff (!rst_n)
        pll_word.valid |-> (pll_word.nfraq_byte2[0] == 1'b1)
                        && (pll_word.nfraq_byte2[7] == 1'b0)
                        && (pll_word.nint_byte[0] == 1'b0))
        else $error("register byte marker bits wrong");

    // Flag bit follows the mode register (the user must keep config static while busy; not enforced).
    a_frac_flag: assert property (@(posedge clk) disable iff (!rst_n)
        pll_word.valid |-> (pll_word.nint_byte[1] == frac_mode_reg))
        else $error("fractional flag does not match mode register");

    // Zero reference gives zero N and fraction.
    a_zero_ref: assert property (@(posedge clk) disable iff (!rst_n)
        (pll_word.valid && (ref_freq_reg == '0)) |->
            (pll_word.nint_byte[7:2] == '0) && (pll_word.nfraq_byte0 == '0)
            && (pll_word.nfraq_byte1 == '0) && (pll_word.nfraq_byte2[6:1] == '0))
        else $error("nonzero word with zero reference");

    // Front keeps its beat valid while the full queue refuses it.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && !push_ready) |=> push_valid)
        else $error("front lost a beat while queue full");

endmodule
